/* rtl/cv3bc_pkg.sv */
// Shared types and constants of the 3x3 convolution block with copied borders.
// Used by the front, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package cv3bc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WCFG_W   = 11;
  localparam int HCFG_W   = 13;
  localparam int POS_W    = COL_W + ROW_W;
  localparam int TOT_W    = POS_W + 1;
  localparam int OWED_W   = COL_W + 1;
  localparam int COEF_W   = 16;
  localparam int KROW_W   = 3 * COEF_W;
  localparam int PROD_W   = PIX_W + 1 + COEF_W;
  localparam int RSUM_W   = PROD_W + 2;
  localparam int SUM_W    = RSUM_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KROW_W;
  localparam int OUT_DATA_W = 32;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // divider sequencing: a wait state, a load state, then one step per quotient bit
  localparam int DIV_LOAD  = POS_W + 1;
  localparam int DIV_START = POS_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_START + 1);

  localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(480);
  localparam logic [KROW_W-1:0] KTOP_RST   = '0;
  localparam logic [KROW_W-1:0] KMID_RST   = KROW_W'(48'h0000_0100_0000);
  localparam logic [KROW_W-1:0] KBOT_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } cv3bc_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } cv3bc_op_e;

  typedef enum logic [1:0] {
    SRC_WINDOW = 2'd0,
    SRC_LOWER  = 2'd1,
    SRC_UPPER  = 2'd2,
    SRC_ZERO   = 2'd3
  } cv3bc_src_e;

  typedef struct packed {
    cv3bc_op_e         op;
    cv3bc_src_e        src;
    logic [COL_W-1:0]  addr;
    logic [PIX_W-1:0]  pix;
    logic              emit;
    logic              interior;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } cv3bc_item_t;

  typedef logic [2:0][KROW_W-1:0] cv3bc_kernel_t;

endpackage

/* rtl/cv3bc_front.sv */
// Front end: accepts stream items, keeps input/output position counters and
// classifies each item into a queue request. Depends on cv3bc_pkg.
`timescale 1ns / 1ps

module cv3bc_front import cv3bc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cv3bc_op_e          in_op_i,
  input  logic [PIX_W-1:0]   in_pix_i,
  input  logic [WCFG_W-1:0]  width_i,
  input  logic [HCFG_W-1:0]  height_i,
  input  logic               size_wr_i,
  input  logic               full_i,
  output logic               push_o,
  output cv3bc_item_t        item_o
);

  logic [WCFG_W-1:0]    w_q;
  logic [HCFG_W-1:0]    h_q;
  logic [TOT_W-1:0]     total_q;

  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [OWED_W-1:0]    owed_q, owed_d;
  logic                 draining_q, draining_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [ROW_W-1:0]     orow_q, orow_d;
  logic [COL_W-1:0]     ocol_q, ocol_d;

  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [POS_W-1:0]     dq_q, dq_nx;
  logic [WCFG_W-1:0]    dr_q, dr_nx;
  logic [WCFG_W:0]      div_sh, div_diff;
  logic                 div_ge, busy;

  logic                 accept, pix_op, restart, keep;
  logic [POS_W-1:0]     pos_b, pos_e, pos_nx;
  logic [ROW_W-1:0]     r_b, r_e, r_nx;
  logic [COL_W-1:0]     c_b, c_e, c_nx;
  logic [OWED_W-1:0]    owed_b;
  logic                 wrap0, pos_end, col_end, interior, last, pemit, dok;
  logic [TOT_W-1:0]     pos_inc;
  logic [WCFG_W-1:0]    ic1, wm1, dsub;
  logic                 iwrap;
  logic [HCFG_W-1:0]    ir1;
  logic [COL_W-1:0]     col_nx;
  logic [ROW_W-1:0]     row_nx;
  logic                 owed_le_w, owed_is_w1;

  // effective frame size, saturated to the supported range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WIDTH_RST;
      h_q     <= HEIGHT_RST;
      total_q <= TOT_W'(WIDTH_RST) * TOT_W'(HEIGHT_RST);
    end else begin
      if (width_i == '0) w_q <= WCFG_W'(1);
      else if (width_i > WCFG_W'(MAX_WIDTH)) w_q <= WCFG_W'(MAX_WIDTH);
      else w_q <= width_i;
      if (height_i == '0) h_q <= HCFG_W'(1);
      else if (height_i > HCFG_W'(MAX_HEIGHT)) h_q <= HCFG_W'(MAX_HEIGHT);
      else h_q <= height_i;
      total_q <= TOT_W'(w_q) * TOT_W'(h_q);
    end
  end

  // restoring divider: output row/column from the raster position after a size change
  assign busy     = div_cnt_q != '0;
  assign div_sh   = {dr_q, dq_q[POS_W-1]};
  assign div_diff = div_sh - {1'b0, w_q};
  assign div_ge   = div_sh >= {1'b0, w_q};
  assign dr_nx    = div_ge ? div_diff[WCFG_W-1:0] : div_sh[WCFG_W-1:0];
  assign dq_nx    = {dq_q[POS_W-2:0], div_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (size_wr_i) begin
      div_cnt_q <= DIV_CNT_W'(DIV_START);
    end else if (busy) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_cnt_q == DIV_CNT_W'(DIV_LOAD)) begin
      dq_q <= pos_q;
      dr_q <= '0;
    end else if (busy) begin
      dq_q <= dq_nx;
      dr_q <= dr_nx;
    end
  end

  assign in_ready_o = !busy && !full_i && !size_wr_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pix_op     = in_op_i == OP_PIXEL;
  assign restart    = pix_op && draining_q;

  // a pixel after a drain starts a fresh pipeline
  assign pos_b  = restart ? '0 : pos_q;
  assign r_b    = restart ? '0 : orow_q;
  assign c_b    = restart ? '0 : ocol_q;
  assign owed_b = restart ? '0 : owed_q;

  assign wrap0   = {1'b0, pos_b} >= total_q;
  assign pos_e   = wrap0 ? '0 : pos_b;
  assign r_e     = wrap0 ? '0 : r_b;
  assign c_e     = wrap0 ? '0 : c_b;
  assign pos_inc = {1'b0, pos_e} + TOT_W'(1);
  assign pos_end = pos_inc >= total_q;
  assign col_end = ({1'b0, c_e} + WCFG_W'(1)) == w_q;
  assign pos_nx  = pos_end ? '0 : pos_inc[POS_W-1:0];
  assign r_nx    = pos_end ? '0 : (col_end ? r_e + ROW_W'(1) : r_e);
  assign c_nx    = (pos_end || col_end) ? '0 : c_e + COL_W'(1);

  assign interior = (r_e != '0) && (({1'b0, r_e} + HCFG_W'(1)) < h_q) &&
                    (c_e != '0) && (({1'b0, c_e} + WCFG_W'(1)) < w_q);
  assign last     = ({1'b0, r_e} == h_q - HCFG_W'(1)) && ({1'b0, c_e} == w_q - WCFG_W'(1));

  // input raster position
  assign ic1    = {1'b0, col_q} + WCFG_W'(1);
  assign iwrap  = ic1 >= w_q;
  assign ir1    = {1'b0, row_q} + HCFG_W'(iwrap);
  assign row_nx = (ir1 >= h_q) ? '0 : ir1[ROW_W-1:0];
  assign col_nx = iwrap ? '0 : ic1[COL_W-1:0];

  assign pemit      = {1'b0, owed_b} >= ({1'b0, w_q} + (WCFG_W + 1)'(1));
  assign dok        = (owed_q != '0) && (row_q == '0) && (col_q == '0);
  assign owed_le_w  = owed_q <= w_q;
  assign owed_is_w1 = {1'b0, owed_q} == ({1'b0, w_q} + (WCFG_W + 1)'(1));
  assign wm1        = w_q - WCFG_W'(1);
  assign dsub       = w_q - owed_q;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    owed_d     = owed_q;
    draining_d = draining_q;
    pos_d      = pos_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    keep       = 1'b0;
    item_o     = '0;
    item_o.row      = r_e;
    item_o.col      = c_e;
    item_o.last     = last;
    item_o.pix      = in_pix_i;
    if (accept) begin
      if (pix_op) begin
        keep            = 1'b1;
        item_o.op       = OP_PIXEL;
        item_o.src      = SRC_WINDOW;
        item_o.addr     = col_q;
        item_o.emit     = pemit;
        item_o.interior = interior;
        col_d           = col_nx;
        row_d           = row_nx;
        draining_d      = 1'b0;
        if (pemit) begin
          owed_d = owed_b;
          pos_d  = pos_nx;
          orow_d = r_nx;
          ocol_d = c_nx;
        end else begin
          owed_d = owed_b + OWED_W'(1);
          pos_d  = pos_b;
          orow_d = r_b;
          ocol_d = c_b;
        end
      end else if (dok) begin
        keep        = 1'b1;
        item_o.op   = OP_DRAIN;
        item_o.emit = 1'b1;
        if (owed_le_w) begin
          item_o.src  = SRC_LOWER;
          item_o.addr = dsub[COL_W-1:0];
        end else if (owed_is_w1) begin
          item_o.src  = SRC_UPPER;
          item_o.addr = wm1[COL_W-1:0];
        end else begin
          item_o.src  = SRC_ZERO;
        end
        owed_d     = owed_q - OWED_W'(1);
        draining_d = 1'b1;
        pos_d      = pos_nx;
        orow_d     = r_nx;
        ocol_d     = c_nx;
      end
    end
  end

  assign push_o = keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      owed_q     <= '0;
      draining_q <= 1'b0;
      pos_q      <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      owed_q     <= owed_d;
      draining_q <= draining_d;
      pos_q      <= pos_d;
      if (div_cnt_q == DIV_CNT_W'(1)) begin
        orow_q <= dq_nx[ROW_W-1:0];
        ocol_q <= dr_nx[COL_W-1:0];
      end else begin
        orow_q <= orow_d;
        ocol_q <= ocol_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ocol_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ({1'b0, ocol_q} < w_q))
    else $error("output column beyond frame width");
  a_owed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= OWED_W'(MAX_WIDTH + 1))
    else $error("owed output count out of range");
`endif

endmodule

/* rtl/cv3bc_queue.sv */
// Short first-word-fall-through queue of classified requests between front and back.
// Depends on cv3bc_pkg.
`timescale 1ns / 1ps

module cv3bc_queue import cv3bc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cv3bc_item_t  item_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output cv3bc_item_t  head_o
);

  cv3bc_item_t       entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W + 1)'(QDEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("request popped from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* rtl/cv3bc_back.sv */
// Back end: line stores, 3x3 window, pipelined multiply-accumulate and output register.
// Depends on cv3bc_pkg; fed from cv3bc_queue.
`timescale 1ns / 1ps

module cv3bc_back import cv3bc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  cv3bc_item_t        item_i,
  output logic               pop_o,
  input  cv3bc_kernel_t      kernel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   out_pix_o,
  output logic [ROW_W-1:0]   out_row_o,
  output logic [COL_W-1:0]   out_col_o,
  output logic               out_last_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic adv, mem_we, hazard;

  // stage 1: line store read
  logic             v1_q, fwd1_q;
  cv3bc_item_t      ent1_q;
  logic [PIX_W-1:0] rd_up_q, rd_lo_q, fup1_q, flo1_q;
  logic [PIX_W-1:0] up_eff, lo_eff, dcenter;

  // stage 2: window holds this item's taps
  logic             v2_q;
  cv3bc_item_t      ent2_q;
  logic [PIX_W-1:0] dval2_q, copy2;
  logic [PIX_W-1:0] win_q [3][3];
  logic signed [PROD_W-1:0] prod_d [3][3];

  // stage 3: products
  logic             v3_q;
  cv3bc_item_t      ent3_q;
  logic [PIX_W-1:0] copy3_q;
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [RSUM_W-1:0] rsum_d [3];

  // stage 4: row sums
  logic             v4_q;
  cv3bc_item_t      ent4_q;
  logic [PIX_W-1:0] copy4_q;
  logic signed [RSUM_W-1:0] rsum_q [3];
  logic signed [SUM_W-1:0]  sum;
  logic [PIX_W-1:0] fval;

  logic out_vld_q;

  // hold the whole back pipeline while the output register is stalled
  assign adv    = !out_vld_q || out_ready_i;
  assign pop_o  = adv && !empty_i;
  assign mem_we = adv && v1_q && (ent1_q.op == OP_PIXEL);
  assign hazard = v1_q && (ent1_q.op == OP_PIXEL) && (ent1_q.addr == item_i.addr);

  // the store written this cycle is read at the same edge: forward its new data
  assign up_eff = fwd1_q ? fup1_q : rd_up_q;
  assign lo_eff = fwd1_q ? flo1_q : rd_lo_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[ent1_q.addr] <= lo_eff;
      lower_mem[ent1_q.addr] <= ent1_q.pix;
    end
    if (pop_o) begin
      rd_up_q <= upper_mem[item_i.addr];
      rd_lo_q <= lower_mem[item_i.addr];
    end
  end

  always_comb begin
    case (ent1_q.src)
      SRC_LOWER: dcenter = lo_eff;
      SRC_UPPER: dcenter = up_eff;
      default:   dcenter = '0;
    endcase
  end

  assign copy2 = (ent2_q.op == OP_PIXEL) ? win_q[1][1] : dval2_q;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[n][k] = $signed({1'b0, win_q[n][k]}) *
                       $signed(kernel_i[n][k*COEF_W +: COEF_W]);
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      rsum_d[n] = RSUM_W'(prod_q[n][0]) + RSUM_W'(prod_q[n][1]) + RSUM_W'(prod_q[n][2]);
    end
  end

  // floor by 8 bits, clamp to the pixel range
  assign sum = SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2]);
  always_comb begin
    if (sum[SUM_W-1]) fval = '0;
    else if (|sum[SUM_W-2:16]) fval = '1;
    else fval = sum[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int n = 0; n < 3; n++) begin
        for (int k = 0; k < 3; k++) win_q[n][k] <= '0;
      end
    end else if (adv) begin
      v1_q      <= !empty_i;
      v2_q      <= v1_q && ent1_q.emit;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      out_vld_q <= v4_q;
      if (mem_we) begin
        for (int n = 0; n < 3; n++) begin
          win_q[n][0] <= win_q[n][1];
          win_q[n][1] <= win_q[n][2];
        end
        win_q[0][2] <= up_eff;
        win_q[1][2] <= lo_eff;
        win_q[2][2] <= ent1_q.pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent1_q <= item_i;
      fwd1_q <= hazard;
      fup1_q <= lo_eff;
      flo1_q <= ent1_q.pix;
    end
    if (adv) begin
      ent2_q  <= ent1_q;
      dval2_q <= dcenter;
      ent3_q  <= ent2_q;
      copy3_q <= copy2;
      prod_q  <= prod_d;
      ent4_q  <= ent3_q;
      copy4_q <= copy3_q;
      rsum_q  <= rsum_d;
      if (v4_q) begin
        out_pix_o  <= ent4_q.interior ? fval : copy4_q;
        out_row_o  <= ent4_q.row;
        out_col_o  <= ent4_q.col;
        out_last_o <= ent4_q.last;
      end
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

/* rtl/convolve_3x3_border_copy.sv */
// 3x3 convolution with copied borders: top level with configuration registers,
// front end, request queue and back end. Depends on cv3bc_pkg and all cv3bc_* modules.
//
// Usage: grey pixels enter in raster order on the slave stream, one per beat;
// tuser low marks a pixel, tuser high a drain request that flushes one owed output
// once a frame has been fully delivered. Each output for raster position p leaves
// with input p + width + 1; after the frame, width + 1 drain requests flush the rest.
// The master stream carries the filtered or copied pixel with its row and column;
// tlast is high on the last pixel of the frame.
// Throughput: one item per clock unless the receiver stalls or a size change is busy.
// Latency: a result is registered after the item causing it is accepted and passes
// the queue, line store read, window, products, row sums and clamp stages.
// Configuration: plain write port; a write of width or height makes the block busy
// while a 22-step divider rebuilds the output row and column.
// Reset: counters cleared, 640x480 frame, identity kernel; line stores hold garbage
// until written by pixels. When the receiver stalls, the back pipeline holds and the
// four-entry queue keeps accepting until full, then tready drops.
`timescale 1ns / 1ps

module convolve_3x3_border_copy import cv3bc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel_in
  input  logic                    s_axis_tuser,   // [0] op
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] pixel_out, [19:8] out_row,
                                                  // [29:20] out_column, [31:30] zero
  output logic                    m_axis_tlast,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic [KROW_W-1:0] ktop_q, kmid_q, kbot_q;
  cv3bc_kernel_t     kernel;
  logic              size_wr;

  logic              push, full, pop, empty;
  cv3bc_item_t       push_item, head_item;
  logic [PIX_W-1:0]  out_pix;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      ktop_q   <= KTOP_RST;
      kmid_q   <= KMID_RST;
      kbot_q   <= KBOT_RST;
    end else if (cfg_we_i) begin
      unique case (cv3bc_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_wdata_i[WCFG_W-1:0];
        REG_HEIGHT: height_q <= cfg_wdata_i[HCFG_W-1:0];
        REG_KTOP:   ktop_q   <= cfg_wdata_i;
        REG_KMID:   kmid_q   <= cfg_wdata_i;
        REG_KBOT:   kbot_q   <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign size_wr = cfg_we_i && ((cv3bc_reg_e'(cfg_idx_i) == REG_WIDTH) ||
                                (cv3bc_reg_e'(cfg_idx_i) == REG_HEIGHT));

  always_comb begin
    kernel[0] = ktop_q;
    kernel[1] = kmid_q;
    kernel[2] = kbot_q;
  end

  cv3bc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (cv3bc_op_e'(s_axis_tuser)),
    .in_pix_i   (s_axis_tdata),
    .width_i    (width_q),
    .height_i   (height_q),
    .size_wr_i  (size_wr),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  cv3bc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_item)
  );

  cv3bc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .kernel_i    (kernel),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_col, out_row, out_pix};

endmodule
